// File: design/assert_macros.svh
// Shared concurrent assertion macro
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// File: design/rcl_pkg.sv
package rcl_pkg;

    localparam int CharW  = 8;
    localparam int CountW = 7;
    localparam int OutW   = 24;

    typedef enum logic [2:0] {
        K_TIME,
        K_DATE,
        K_WAIT,
        K_DATE_NULL,
        K_ID,
        K_ACT
    } kind_t;

    localparam logic [5:0] E_TIME = 6'd1;
    localparam logic [5:0] E_DATE = 6'd2;
    localparam logic [5:0] E_WAIT = 6'd4;
    localparam logic [5:0] E_ID   = 6'd8;
    localparam logic [5:0] E_ACT  = 6'd16;
    localparam logic [5:0] E_MISS = 6'd32;

    typedef struct packed {
        logic [3:0]  field_index;
        logic [3:0]  char_position;
        logic [6:0]  first_number;
        logic [6:0]  second_number;
        logic [6:0]  year_hi;
        logic [6:0]  year_lo;
        logic [7:0]  relay_number;
        logic [3:0]  word_match_flags;
        logic        token_bad;
        logic [5:0]  error_flags;
        logic [7:0]  pair_count;
        logic        in_separator;
        logic        line_format;
        logic        at_line_start;
    } rcl_state_t;

    typedef struct packed {
        logic       line_ok;
        logic       empty_error;
        logic       time_error;
        logic       date_error;
        logic       wait_error;
        logic       id_error;
        logic       action_error;
        logic       missing_error;
        logic       no_command_warning;
        logic [7:0] command_count;
    } rcl_result_t;

    function automatic logic [3:0] pair_start(input logic lf);
        return lf ? 4'd5 : 4'd2;
    endfunction

    function automatic kind_t field_kind(input logic [3:0] fi, input logic lf);
        kind_t k;
        k = K_ACT;
        if (fi < pair_start(lf)) begin
            if (lf) begin
                case (fi)
                    4'd0:    k = K_TIME;
                    4'd1:    k = K_DATE;
                    4'd2:    k = K_WAIT;
                    4'd3:    k = K_TIME;
                    default: k = K_DATE_NULL;
                endcase
            end else begin
                k = (fi == 4'd0) ? K_TIME : K_DATE;
            end
        end else if (fi == pair_start(lf)) begin
            k = K_ID;
        end
        return k;
    endfunction

    // Letters of on, off, toggle, wait; zero past a word's end
    function automatic logic [7:0] word_char(input logic [1:0] w, input logic [3:0] p);
        logic [7:0] ch;
        ch = 8'h00;
        case (w)
            2'd0: begin
                case (p)
                    4'd0:    ch = "o";
                    4'd1:    ch = "n";
                    default: ch = 8'h00;
                endcase
            end
            2'd1: begin
                case (p)
                    4'd0:    ch = "o";
                    4'd1:    ch = "f";
                    4'd2:    ch = "f";
                    default: ch = 8'h00;
                endcase
            end
            2'd2: begin
                case (p)
                    4'd0:    ch = "t";
                    4'd1:    ch = "o";
                    4'd2:    ch = "g";
                    4'd3:    ch = "g";
                    4'd4:    ch = "l";
                    4'd5:    ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            default: begin
                case (p)
                    4'd0:    ch = "w";
                    4'd1:    ch = "a";
                    4'd2:    ch = "i";
                    4'd3:    ch = "t";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

    function automatic logic [3:0] word_len(input logic [1:0] w);
        logic [3:0] n;
        case (w)
            2'd0:    n = 4'd2;
            2'd1:    n = 4'd3;
            2'd2:    n = 4'd6;
            default: n = 4'd4;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
            4'd2:                                        n = 5'd28;
            default:                                     n = 5'd0;
        endcase
        return n;
    endfunction

    localparam rcl_state_t LINE_CLEAR = '{
        field_index: 4'd0, char_position: 4'd0, first_number: 7'd0,
        second_number: 7'd0, year_hi: 7'd0, year_lo: 7'd0, relay_number: 8'd0,
        word_match_flags: 4'hF, token_bad: 1'b0, error_flags: 6'd0,
        pair_count: 8'd0, in_separator: 1'b1, line_format: 1'b0,
        at_line_start: 1'b1
    };

endpackage

// File: design/rcl_parse.sv
module rcl_parse
    import rcl_pkg::*;
(
    input  rcl_state_t        st,
    input  logic [CharW-1:0]  char_code,
    input  logic              line_end,
    input  logic              repeat_line,
    input  logic [CountW-1:0] relay_count,
    output rcl_state_t        st_next,
    output rcl_result_t       result
);

    rcl_state_t  s;
    kind_t       kind;
    logic        is_ws;
    logic        is_dig;
    logic        do_end;
    logic        bad;
    logic        ok;
    logic        leap;
    logic [3:0]  p;
    logic [3:0]  ps;
    logic [7:0]  d;
    logic [7:0]  lc;
    logic [10:0] acc;
    logic [11:0] racc;
    logic [4:0]  mlen;

    always_comb
    begin
        s      = st;
        result = '0;
        do_end = 1'b0;
        bad    = 1'b0;
        ok     = 1'b0;
        leap   = 1'b0;
        mlen   = 5'd0;
        acc    = '0;
        racc   = '0;
        is_ws  = (char_code == 8'h20) || (char_code >= 8'h09 && char_code <= 8'h0D);
        is_dig = (char_code >= 8'h30) && (char_code <= 8'h39);
        d      = char_code - 8'h30;
        lc     = (char_code >= 8'h41 && char_code <= 8'h5A) ? char_code + 8'h20 : char_code;

        if (s.at_line_start)
        begin
            s.line_format   = repeat_line;
            s.at_line_start = 1'b0;
        end
        ps   = pair_start(s.line_format);
        kind = field_kind(s.field_index, s.line_format);
        p    = s.char_position;

        if (is_ws)
        begin
            do_end = !s.in_separator;
        end
        else
        begin
            if (s.in_separator)
            begin
                s.in_separator     = 1'b0;
                s.char_position    = 4'd0;
                s.token_bad        = 1'b0;
                s.first_number     = 7'd0;
                s.second_number    = 7'd0;
                s.year_hi          = 7'd0;
                s.year_lo          = 7'd0;
                s.relay_number     = 8'd0;
                s.word_match_flags = 4'hF;
                if (kind == K_ACT && s.pair_count != 8'hFF)
                    s.pair_count = s.pair_count + 8'd1;
            end
            p = s.char_position;
            case (kind)
                K_TIME:
                begin
                    if (p == 4'd2 || p == 4'd5)
                    begin
                        if (char_code != 8'h3A) s.token_bad = 1'b1;
                    end
                    else if (p >= 4'd8 || !is_dig)
                        s.token_bad = 1'b1;
                    else if (p == 4'd0 || p == 4'd3 || p == 4'd6)
                        s.first_number = d[6:0];
                    else
                    begin
                        acc = 11'(s.first_number) * 11'd10 + 11'(d);
                        s.first_number = acc[6:0];
                        if (acc[6:0] > ((p == 4'd1) ? 7'd23 : 7'd59)) s.token_bad = 1'b1;
                    end
                end
                K_DATE, K_DATE_NULL:
                begin
                    if (p == 4'd2 || p == 4'd5)
                    begin
                        if (char_code != 8'h2F) s.token_bad = 1'b1;
                    end
                    else if (p >= 4'd10 || !is_dig)
                        s.token_bad = 1'b1;
                    else
                    begin
                        // hold the year as two decimal halves for the leap test
                        if (p < 4'd2)
                            acc = 11'(s.first_number) * 11'd10 + 11'(d);
                        else if (p < 4'd5)
                            acc = 11'(s.second_number) * 11'd10 + 11'(d);
                        else if (p < 4'd8)
                            acc = 11'(s.year_hi) * 11'd10 + 11'(d);
                        else
                            acc = 11'(s.year_lo) * 11'd10 + 11'(d);
                        if (p < 4'd2)      s.first_number  = acc[6:0];
                        else if (p < 4'd5) s.second_number = acc[6:0];
                        else if (p < 4'd8) s.year_hi       = acc[6:0];
                        else               s.year_lo       = acc[6:0];
                    end
                end
                K_ID:
                begin
                    if (p == 4'd0)
                    begin
                        if (char_code != 8'h72 && char_code != 8'h52) s.token_bad = 1'b1;
                    end
                    else if (!is_dig)
                        s.token_bad = 1'b1;
                    else
                    begin
                        racc = 12'(s.relay_number) * 12'd10 + 12'(d);
                        s.relay_number = (racc > 12'd255) ? 8'hFF : racc[7:0];
                    end
                end
                default:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (p >= word_len(2'(i)) || word_char(2'(i), p) != lc)
                            s.word_match_flags[i] = 1'b0;
                    end
                end
            endcase
            if (s.char_position != 4'hF)
                s.char_position = s.char_position + 4'd1;
            if (line_end) do_end = 1'b1;
        end

        if (line_end && !s.in_separator) do_end = 1'b1;

        if (do_end)
        begin
            bad = s.token_bad;
            case (kind)
                K_TIME:
                begin
                    if (s.char_position != 4'd8 || bad) s.error_flags |= E_TIME;
                end
                K_DATE, K_DATE_NULL:
                begin
                    if (s.char_position != 4'd10) bad = 1'b1;
                    if (!bad)
                    begin
                        if (s.second_number > 7'd12)
                            bad = 1'b1;
                        else
                        begin
                            leap = (s.year_lo == 7'd0) ? (s.year_hi[1:0] == 2'd0)
                                                       : (s.year_lo[1:0] == 2'd0);
                            mlen = month_days(s.second_number[3:0]);
                            if (s.second_number == 7'd2 && leap) mlen = 5'd29;
                            if (s.first_number > 7'(mlen)) bad = 1'b1;
                        end
                        if (kind == K_DATE && (s.first_number == 7'd0 ||
                            s.second_number == 7'd0 ||
                            (s.year_hi == 7'd0 && s.year_lo == 7'd0)))
                            bad = 1'b1;
                    end
                    if (bad) s.error_flags |= E_DATE;
                end
                K_WAIT:
                begin
                    if (!(s.word_match_flags[3] && s.char_position == 4'd4))
                        s.error_flags |= E_WAIT;
                end
                K_ID:
                begin
                    if (bad || s.char_position < 4'd2 || s.relay_number > 8'(relay_count))
                        s.error_flags |= E_ID;
                end
                default:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (s.word_match_flags[i] && s.char_position == word_len(2'(i)))
                            ok = 1'b1;
                    end
                    if (!ok) s.error_flags |= E_ACT;
                end
            endcase
            if (kind == K_ACT)
                s.field_index = ps;
            else if (s.field_index != 4'hF)
                s.field_index = s.field_index + 4'd1;
            s.in_separator = 1'b1;
        end

        if (line_end)
        begin
            if (s.field_index == 4'd0)
                result.empty_error = 1'b1;
            else
            begin
                if (s.field_index < ps || (s.field_index == ps && s.pair_count == 8'd0)
                    || s.field_index == ps + 4'd1)
                    s.error_flags |= E_MISS;
                result.line_ok            = (s.error_flags == 6'd0);
                result.time_error         = s.error_flags[0];
                result.date_error         = s.error_flags[1];
                result.wait_error         = s.error_flags[2];
                result.id_error           = s.error_flags[3];
                result.action_error       = s.error_flags[4];
                result.missing_error      = s.error_flags[5];
                result.no_command_warning = (s.field_index == ps + 4'd1) &&
                                            (s.pair_count == 8'd0);
                result.command_count      = s.pair_count;
            end
            st_next = LINE_CLEAR;
            st_next.line_format = s.line_format;
        end
        else
            st_next = s;
    end

endmodule

// File: design/relay_command_line_checker.sv
// A line's result is registered on m_tvalid as its last beat leaves the input stage.
// Throughput: one character beat per cycle; the input register stalls only when the
// result register is still full and the next buffered character ends a line.
// Reset: rst_n clears the parser to start of line and sets relay_count to 64;
// both pipeline stages come up empty.
module relay_command_line_checker
    import rcl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CharW-1:0]  s_tdata,   // char_code
    input  logic              s_tlast,   // line_end
    input  logic              s_tuser,   // repeat_line
    output logic              m_tvalid,
    input  logic              m_tready,
    // line_ok, empty_error, time_error, date_error, wait_error, id_error,
    // action_error, missing_error, no_command_warning, command_count[7:0], zero pad
    output logic [OutW-1:0]   m_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CountW-1:0] cfg_data   // relay_count
);

    logic              in_valid_reg;
    logic [CharW-1:0]  char_reg;
    logic              last_reg;
    logic              rep_reg;
    logic [CountW-1:0] relay_count_reg;
    rcl_state_t        st_reg;
    rcl_state_t        st_next;
    rcl_result_t       result;
    logic              out_valid_reg;
    logic [OutW-1:0]   out_data_reg;
    logic              out_free;
    logic              advance;

    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && (!last_reg || out_free);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    rcl_parse u_parse (
        .st          (st_reg),
        .char_code   (char_reg),
        .line_end    (last_reg),
        .repeat_line (rep_reg),
        .relay_count (relay_count_reg),
        .st_next     (st_next),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            st_reg          <= LINE_CLEAR;
            relay_count_reg <= CountW'(64);
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                relay_count_reg <= cfg_data;
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                st_reg <= st_next;
            if (advance && last_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
            rep_reg  <= s_tuser;
        end
        // load the result beat at line end
        if (advance && last_reg)
        begin
            out_data_reg <= {7'd0, result.command_count, result.no_command_warning,
                             result.missing_error, result.action_error, result.id_error,
                             result.wait_error, result.date_error, result.time_error,
                             result.empty_error, result.line_ok};
        end
    end

endmodule

// File: design/rcl_checker.sv
`include "assert_macros.svh"

module rcl_checker
    import rcl_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [CharW-1:0]  s_tdata,
    input logic              s_tlast,
    input logic              s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OutW-1:0]   m_tdata,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [CountW-1:0] cfg_data
);

    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped")
    `ASSERT_CLK(a_ok_clean, m_tvalid && m_tdata[0] |-> m_tdata[8:1] == 8'd0, "ok with error")
    `ASSERT_CLK(a_empty_only, m_tvalid && m_tdata[1] |-> m_tdata[16:2] == 15'd0 && !m_tdata[0], "empty line not alone")
    `ASSERT_CLK(a_nocmd_miss, m_tvalid && m_tdata[8] |-> m_tdata[7], "no command without missing")
    `ASSERT_CLK(a_pad_zero, m_tvalid |-> m_tdata[23:17] == 7'd0, "pad bits set")

endmodule

bind relay_command_line_checker rcl_checker u_rcl_checker (.*);
